// ----- hdl/positional_insert_remove_queue_defines.svh -----
// Assertion macros for the positional insert/remove queue.
// Included by the RTL file that carries concurrent checks; no dependencies.
`ifndef POSITIONAL_INSERT_REMOVE_QUEUE_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define PIRQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed: label");

// Same-cycle implication
`define PIRQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");

// Next-cycle implication
`define PIRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");

`endif

// ----- hdl/pirq_pkg.sv -----
// Shared constants, codes and types of the positional insert/remove queue.
// No dependencies; the interface, cell and top-level files import it.
`default_nettype none

package pirq_pkg;

    // Store depth and derived widths
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // positions run from 0 to DEPTH, as the count does
    localparam int POS_W  = $clog2(DEPTH + 1);
    // width wide enough to compare a position against the count
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request commands
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // What every cell of the row does this cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_cell_op;

    // Control broadcast along the cell row
    typedef struct packed {
        t_cell_op           op;
        logic [CMP_W-1:0]   pos;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- hdl/pirq_if.sv -----
// Request and result channel interfaces of the positional insert/remove queue.
// Depends on pirq_pkg for field widths.
`default_nettype none

// Request channel: command, value and position
interface pirq_cmd_if import pirq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic signed [DATA_W-1:0]  data_in;
    logic [POS_W-1:0]          position;

    modport source (output valid, cmd, data_in, position, input ready);
    modport sink   (input valid, cmd, data_in, position, output ready);
endinterface

// Result channel: status, removed value, front value, empty flag, count
interface pirq_res_if import pirq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  removed_value;
    logic signed [DATA_W-1:0]  front_value;
    logic                      is_empty;
    logic [CNT_W-1:0]          entry_count;

    modport source (output valid, status, removed_value, front_value, is_empty,
                    entry_count, input ready);
    modport sink   (input valid, status, removed_value, front_value, is_empty,
                    entry_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/pirq_cell.sv -----
// One storage cell of the queue row: holds one entry and shifts with its neighbours.
// Depends on pirq_pkg.
`default_nettype none

module pirq_cell
    import pirq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [CMP_W-1:0]   i_index,    // fixed place of this cell in the row
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic [DATA_W-1:0]  i_data,     // value for an insert
    input  wire logic [DATA_W-1:0]  i_left,     // entry of the cell one place nearer the front
    input  wire logic [DATA_W-1:0]  i_right,    // entry of the cell one place nearer the tail
    output logic [DATA_W-1:0]       o_value,
    output logic [DATA_W-1:0]       o_next,
    output logic [DATA_W-1:0]       o_take      // own entry when it is the one removed
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // Next entry: cells in front of the position keep theirs
    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (i_index == i_ctrl.pos) begin
                    n_value = i_data;
                end else if (i_index > i_ctrl.pos) begin
                    n_value = i_left;
                end
            end
            OP_REMOVE: begin
                if (i_index >= i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Entry storage, payload only
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_next  = n_value;
    assign o_take  = (i_index == i_ctrl.pos) ? r_value : '0;

endmodule

`default_nettype wire

// ----- hdl/positional_insert_remove_queue.sv -----
// Top level of the positional insert/remove queue: request decode, cell row, result register.
// Depends on pirq_pkg, pirq_if, pirq_cell and positional_insert_remove_queue_defines.svh.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  i_cmd    | in        | cmd, data_in, position
//  o_res    | out       | status, removed_value, front_value, is_empty, entry_count
//
// One request is taken per cycle while no result is stalled; every cell of the row
// shifts in that same cycle, so a positional insert or remove takes effect at the
// edge that accepts it. The result appears in the cycle after acceptance, held in
// an output register; a new request is taken while that result is being taken.
// A stalled result holds the request channel back (ready low) until it is taken.
// Reset clears the count and the result valid; stored entries are not cleared.
`default_nettype none
`include "positional_insert_remove_queue_defines.svh"

module positional_insert_remove_queue
    import pirq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pirq_cmd_if.sink    i_cmd,
    pirq_res_if.source  o_res
);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_status;
    logic [DATA_W-1:0]  r_removed;
    logic [DATA_W-1:0]  r_front;
    logic [CNT_W-1:0]   r_out_count;

    logic               w_accept;
    t_cell_ctrl         w_ctrl;
    t_status            w_status;
    logic [CMP_W-1:0]   w_count_x;
    logic [CMP_W-1:0]   w_pos_x;
    logic               w_full;
    logic               w_empty;
    logic [DATA_W-1:0]  w_removed;
    logic [DATA_W-1:0]  w_front;

    logic [DATA_W-1:0]  w_value [DEPTH];
    logic [DATA_W-1:0]  w_next  [DEPTH];
    logic [DATA_W-1:0]  w_take  [DEPTH];

    // Handshake: accept while the result register is free or being emptied
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_count_x = CMP_W'(r_count);
    assign w_pos_x   = CMP_W'(i_cmd.position);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);

    // Request decode into a status and the row operation
    always_comb begin
        w_status   = ST_OK;
        w_ctrl.op  = OP_HOLD;
        w_ctrl.pos = w_pos_x;
        case (t_cmd'(i_cmd.cmd))
            CMD_PUSH: begin
                w_ctrl.pos = w_count_x;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.op = OP_INSERT;
                end
            end
            CMD_POP: begin
                w_ctrl.pos = '0;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.op = OP_REMOVE;
                end
            end
            CMD_INSERT: begin
                if (w_pos_x > w_count_x) begin
                    w_status = ST_BADPOS;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.op = OP_INSERT;
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_count_x) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_ctrl.op = OP_REMOVE;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        // nothing moves without an accepted request
        if (!w_accept) begin
            w_ctrl.op = OP_HOLD;
        end
    end

    // Row of cells; the ends see the request value and their own entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_front
            assign w_left = i_cmd.data_in;
        end else begin : g_mid
            assign w_left = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_value[g];
        end else begin : g_body
            assign w_right = w_value[g+1];
        end

        pirq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CMP_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_data  (i_cmd.data_in),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g]),
            .o_next  (w_next[g]),
            .o_take  (w_take[g])
        );
    end

    // Removed value gathered from the row; only the selected cell contributes
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_removed = w_removed | w_take[k];
        end
        if (w_ctrl.op != OP_REMOVE) begin
            w_removed = '0;
        end
    end

    // Count after the step
    always_comb begin
        case (w_ctrl.op)
            OP_INSERT: n_count = r_count + 1'b1;
            OP_REMOVE: n_count = r_count - 1'b1;
            default:   n_count = r_count;
        endcase
    end

    assign w_front     = (n_count != '0) ? w_next[0] : '0;
    assign n_out_valid = w_accept ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_removed   <= w_removed;
            r_front     <= w_front;
            r_out_count <= n_count;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.removed_value = r_removed;
    assign o_res.front_value   = r_front;
    assign o_res.is_empty      = (r_out_count == '0);
    assign o_res.entry_count   = r_out_count;

    // Checks
    `PIRQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `PIRQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_accept && (w_ctrl.op == OP_INSERT),
        r_count == $past(r_count) + 1'b1)
    `PIRQ_ASSERT_NEXT(a_fail_keeps, i_clk, i_rst_n, w_accept && (w_status != ST_OK),
        r_count == $past(r_count))
    `PIRQ_ASSERT_IMPLY(a_fail_no_value, i_clk, i_rst_n, r_out_valid && (r_status != ST_OK),
        r_removed == '0)

endmodule

`default_nettype wire
